@@ hdl/mandelbrot_escape_time_pixel_macros.svh @@
// Assertion macros used by the escape-time pixel controller.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

`ifndef SYNTH

`define MBET_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define MBET_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define MBET_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define MBET_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/mbet_pkg.sv @@
// Shared constants, types and fixed-point helpers for the escape-time pixel.
package mbet_pkg;

	localparam int FRAC_BITS = 28;
	localparam int Q_W       = 32;
	localparam int PROD_W    = 2 * Q_W;
	localparam int PIX_W     = 10;
	localparam int LIM_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int COLOR_SHIFT = 24;
	localparam int DIV_STEPS = LIM_W + COLOR_SHIFT;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int V_W       = COLOR_SHIFT + 1;

	localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] FOUR = Q_W'(64'd1 << (FRAC_BITS + 2));

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd3;

	typedef struct packed {
		logic signed [Q_W-1:0] offset_x;
		logic signed [Q_W-1:0] offset_y;
		logic [Q_W-1:0]        pixel_step;
		logic [LIM_W-1:0]      iteration_limit;
	} cfg_t;

	typedef struct packed {
		logic load_pixel;
		logic coord_mul;
		logic coord_load;
		logic iter_mul;
		logic iter_add;
		logic div_start;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic escaped;
		logic at_limit;
		logic div_done;
	} dp_stat_t;

	function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] a);
		logic [Q_W-1:0] r;
		r = a[Q_W-1] ? (Q_W'(0) - a) : a;
		return r;
	endfunction

	// Sign and magnitude back to a saturated Q4 value
	function automatic logic signed [Q_W-1:0] from_mag(input logic neg,
			input logic [PROD_W-1:0] r);
		logic over;
		logic [Q_W-1:0] lo;
		logic signed [Q_W-1:0] res;
		over = r > {{(PROD_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
		lo = r[Q_W-1:0];
		if (over)
			res = neg ? QMIN : QMAX;
		else
			res = neg ? $signed(Q_W'(0) - lo) : $signed(lo);
		return res;
	endfunction

	function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		logic signed [Q_W-1:0] res;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1])
			res = s[Q_W] ? QMIN : QMAX;
		else
			res = s[Q_W-1:0];
		return res;
	endfunction

endpackage

@@ hdl/mbet_cfg.sv @@
// Configuration register file: offsets, pixel step and iteration limit.
module mbet_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbet_pkg::CFG_W-1:0]        cfg_data,
	output mbet_pkg::cfg_t                    cfg
);

	mbet_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x        <= mbet_pkg::Q_W'(150);
			cfg_q.offset_y        <= mbet_pkg::Q_W'(190);
			cfg_q.pixel_step      <= mbet_pkg::Q_W'(1342177);
			cfg_q.iteration_limit <= mbet_pkg::LIM_W'(500);
		end else if (cfg_write) begin
			case (cfg_index)
				mbet_pkg::CFG_OFFSET_X:   cfg_q.offset_x <= $signed(cfg_data);
				mbet_pkg::CFG_OFFSET_Y:   cfg_q.offset_y <= $signed(cfg_data);
				mbet_pkg::CFG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data;
				mbet_pkg::CFG_ITER_LIMIT:
					cfg_q.iteration_limit <= cfg_data[mbet_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/mbet_div.sv @@
// Restoring divider for the color scale: (count << 24) / limit, one bit a cycle.
module mbet_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbet_pkg::LIM_W-1:0]    count,
	input  logic [mbet_pkg::LIM_W-1:0]    divisor,
	output logic                          done,
	output logic [mbet_pkg::V_W-1:0]      quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [mbet_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [mbet_pkg::DIV_STEPS-1:0]    dvd_q;
	logic [mbet_pkg::LIM_W-1:0]        rem_q;
	logic [mbet_pkg::V_W-1:0]          quo_q;
	logic [mbet_pkg::LIM_W:0]          shifted;
	logic                              qbit;
	logic [mbet_pkg::LIM_W:0]          diff;

	always_comb begin
		shifted = {rem_q, dvd_q[mbet_pkg::DIV_STEPS-1]};
		qbit = shifted >= {1'b0, divisor};
		diff = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mbet_pkg::DIV_CNT_W'(mbet_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {count, {mbet_pkg::COLOR_SHIFT{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[mbet_pkg::DIV_STEPS-2:0], 1'b0};
			rem_q <= qbit ? diff[mbet_pkg::LIM_W-1:0] : shifted[mbet_pkg::LIM_W-1:0];
			quo_q <= {quo_q[mbet_pkg::V_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/mbet_dp.sv @@
// Datapath: pixel coordinates, the z = z*z + c iteration, count and color.
module mbet_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbet_pkg::cfg_t                cfg,
	input  mbet_pkg::dp_cmd_t             cmd,
	output mbet_pkg::dp_stat_t            stat,
	input  logic [mbet_pkg::PIX_W-1:0]    column,
	input  logic [mbet_pkg::PIX_W-1:0]    row,
	output logic [mbet_pkg::LIM_W-1:0]    iterations,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);

	localparam int Q_W = mbet_pkg::Q_W;
	localparam int PROD_W = mbet_pkg::PROD_W;

	logic [mbet_pkg::PIX_W-1:0]   col_q, row_q;
	logic signed [Q_W-1:0]        cr_q, ci_q, x_q, y_q;
	logic [PROD_W-1:0]            p0_q, p1_q, p2_q;
	logic                         neg0_q, neg1_q, neg2_q;
	logic [mbet_pkg::LIM_W-1:0]   n_q;
	logic [mbet_pkg::LIM_W-1:0]   iter_out_q;
	logic [mbet_pkg::COLOR_SHIFT-1:0] v_out_q;

	logic signed [Q_W:0]          dx, dy;
	logic [Q_W:0]                 dx_abs, dy_abs;
	logic [Q_W-1:0]               a0, b0, a1, b1, a2, b2;
	logic                         s0, s1, s2;
	logic [PROD_W-1:0]            p0, p1, p2;
	logic signed [Q_W-1:0]        xx, yy, xy2, esc_sum;
	logic [mbet_pkg::LIM_W-1:0]   lim_eff;
	logic                         div_done;
	logic [mbet_pkg::V_W-1:0]     quotient;

	assign lim_eff = (cfg.iteration_limit == '0) ? mbet_pkg::LIM_W'(1) : cfg.iteration_limit;

	always_comb begin
		dx = $signed({{(Q_W+1-mbet_pkg::PIX_W){1'b0}}, col_q})
			- $signed({cfg.offset_x[Q_W-1], cfg.offset_x});
		dy = $signed({{(Q_W+1-mbet_pkg::PIX_W){1'b0}}, row_q})
			- $signed({cfg.offset_y[Q_W-1], cfg.offset_y});
		dx_abs = dx[Q_W] ? ((Q_W+1)'(0) - dx) : dx;
		dy_abs = dy[Q_W] ? ((Q_W+1)'(0) - dy) : dy;

		// Share the three multipliers between coordinate set-up and iteration
		if (cmd.coord_mul) begin
			a0 = dx_abs[Q_W-1:0];
			b0 = cfg.pixel_step;
			a1 = dy_abs[Q_W-1:0];
			b1 = cfg.pixel_step;
			a2 = '0;
			b2 = '0;
			s0 = dx[Q_W];
			s1 = dy[Q_W];
			s2 = 1'b0;
		end else begin
			a0 = mbet_pkg::mag(x_q);
			b0 = mbet_pkg::mag(x_q);
			a1 = mbet_pkg::mag(y_q);
			b1 = mbet_pkg::mag(y_q);
			a2 = mbet_pkg::mag(x_q);
			b2 = mbet_pkg::mag(y_q);
			s0 = 1'b0;
			s1 = 1'b0;
			s2 = x_q[Q_W-1] ^ y_q[Q_W-1];
		end
		p0 = PROD_W'(a0) * PROD_W'(b0);
		p1 = PROD_W'(a1) * PROD_W'(b1);
		p2 = PROD_W'(a2) * PROD_W'(b2);
	end

	always_comb begin
		xx  = mbet_pkg::from_mag(1'b0, p0_q >> mbet_pkg::FRAC_BITS);
		yy  = mbet_pkg::from_mag(1'b0, p1_q >> mbet_pkg::FRAC_BITS);
		xy2 = mbet_pkg::from_mag(neg2_q, p2_q >> (mbet_pkg::FRAC_BITS - 1));
		esc_sum = mbet_pkg::sat_add(xx, yy);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			col_q <= column;
			row_q <= row;
		end
		if (cmd.coord_mul || cmd.iter_mul) begin
			p0_q   <= p0;
			p1_q   <= p1;
			p2_q   <= p2;
			neg0_q <= s0;
			neg1_q <= s1;
			neg2_q <= s2;
		end
		if (cmd.coord_load) begin
			cr_q <= mbet_pkg::from_mag(neg0_q, p0_q);
			ci_q <= mbet_pkg::from_mag(neg1_q, p1_q);
			x_q  <= '0;
			y_q  <= '0;
		end else if (cmd.iter_add) begin
			x_q <= mbet_pkg::sat_add(mbet_pkg::sat_add(xx, Q_W'(0) - yy), cr_q);
			y_q <= mbet_pkg::sat_add(xy2, ci_q);
		end
		if (cmd.out_load) begin
			iter_out_q <= n_q;
			v_out_q    <= quotient[mbet_pkg::COLOR_SHIFT-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.coord_load) begin
			n_q <= '0;
		end else if (cmd.iter_add) begin
			n_q <= n_q + 1'b1;
		end
	end

	mbet_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.count    (n_q),
		.divisor  (lim_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	assign stat.escaped  = esc_sum > mbet_pkg::FOUR;
	assign stat.at_limit = n_q == lim_eff;
	assign stat.div_done = div_done;

	assign iterations = iter_out_q;
	assign red   = v_out_q[15:8];
	assign green = v_out_q[7:0];
	assign blue  = v_out_q[23:16];

endmodule

@@ hdl/mbet_ctrl.sv @@
// Controller: sequences set-up, iteration, color division and result hand-off.
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mbet_pkg::dp_cmd_t     cmd,
	input  mbet_pkg::dp_stat_t    stat
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COORD = 3'd1;
	localparam logic [2:0] S_CLOAD = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_pixel = 1'b1;
					state_d = S_COORD;
				end
			end
			S_COORD: begin
				cmd.coord_mul = 1'b1;
				state_d = S_CLOAD;
			end
			S_CLOAD: begin
				cmd.coord_load = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.iter_mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				// escape test sees the squares of the latest z
				if (stat.escaped || stat.at_limit) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.iter_add = 1'b1;
					state_d = S_MUL;
				end
			end
			S_DIV: begin
				if (stat.div_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	`MBET_ASSERT_NXT(a_iter_loops, clk, arst_n, (state_q == S_ADD) && !stat.escaped && !stat.at_limit, state_q == S_MUL)
	`MBET_ASSERT_NXT(a_div_to_done, clk, arst_n, (state_q == S_DIV) && stat.div_done, state_q == S_DONE)
	`MBET_ASSERT_NXT(a_result_shown, clk, arst_n, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE))

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// One pixel at a time: in_stall is high from acceptance until its result goes to the output register.
// A result that finds the output register still stalled waits in the done state.
// Each iteration has a multiply step, then an add and escape test step.
// The color scale is a 40-step restoring divide, one quotient bit a cycle.
// A finished result waits in the output register while the next pixel is accepted.
// Reset (arst_n low) clears the sequencer and loads the configuration defaults.
module mandelbrot_escape_time_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mbet_pkg::PIX_W-1:0]        column,
	input  logic [mbet_pkg::PIX_W-1:0]        row,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mbet_pkg::LIM_W-1:0]        iterations,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	input  logic                              cfg_write,
	input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbet_pkg::CFG_W-1:0]        cfg_data
);

	mbet_pkg::cfg_t     cfg;
	mbet_pkg::dp_cmd_t  cmd;
	mbet_pkg::dp_stat_t stat;

	mbet_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbet_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.column     (column),
		.row        (row),
		.iterations (iterations),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ tb/sv/tb_mandelbrot_escape_time_pixel.sv @@
// Testbench for the escape-time pixel: directed views, then random views under varying idle.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel;

	localparam int FRAC_BITS   = mbet_pkg::FRAC_BITS;
	localparam int COLOR_SHIFT = mbet_pkg::COLOR_SHIFT;
	localparam int PIX_W       = mbet_pkg::PIX_W;
	localparam int LIM_W       = mbet_pkg::LIM_W;
	localparam int CFG_IDX_W   = mbet_pkg::CFG_IDX_W;
	localparam int CFG_W       = mbet_pkg::CFG_W;

	localparam longint Q_HI   = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_LO   = -64'sh0000_0000_8000_0000;
	localparam longint Q_FOUR = longint'(1) << (FRAC_BITS + 2);

	typedef struct {
		logic [PIX_W-1:0] column;
		logic [PIX_W-1:0] row;
		logic [LIM_W-1:0] iterations;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} pixel_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PIX_W-1:0]  column = '0;
	logic [PIX_W-1:0]  row = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [LIM_W-1:0]  iterations;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic              cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	// View currently programmed into the block, reset values first
	logic signed [31:0] view_offset_x = 32'sd150;
	logic signed [31:0] view_offset_y = 32'sd190;
	logic [31:0]        view_step = 32'd1342177;
	logic [LIM_W-1:0]   view_limit = 16'd500;

	pixel_result_t pending_pixels[$];
	int fail_count = 0;
	int send_gap_pct = 0;
	int recv_hold_pct = 0;

	mandelbrot_escape_time_pixel i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.column     (column),
		.row        (row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.iterations (iterations),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint q_from_mag(input logic neg, input longint unsigned r);
		if (r > Q_HI)
			return neg ? Q_LO : Q_HI;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sat_sum(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > Q_HI)
			return Q_HI;
		if (s < Q_LO)
			return Q_LO;
		return s;
	endfunction

	// Exact product, shifted right with truncation toward zero, saturated
	function automatic longint fx_mul(input longint a, input longint b, input int sh);
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned prod;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		prod = (ma * mb) >> sh;
		return q_from_mag((a < 0) != (b < 0), prod);
	endfunction

	function automatic longint pixel_coord(input logic [PIX_W-1:0] pix,
			input logic signed [31:0] off);
		longint d;
		longint unsigned md;
		longint unsigned r;
		d = longint'(pix) - longint'(off);
		md = (d < 0) ? -d : d;
		r = md * longint'(view_step);
		return q_from_mag(d < 0, r);
	endfunction

	function automatic pixel_result_t escape_pixel(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] rw);
		pixel_result_t res;
		longint cr;
		longint ci;
		longint x;
		longint y;
		longint xx;
		longint yy;
		longint xy2;
		logic [63:0] n;
		logic [63:0] lim;
		logic [63:0] v;
		cr = pixel_coord(col, view_offset_x);
		ci = pixel_coord(rw, view_offset_y);
		x = 0;
		y = 0;
		n = 0;
		lim = (view_limit == 0) ? 64'd1 : 64'(view_limit);
		while (n < lim) begin
			xx = fx_mul(x, x, FRAC_BITS);
			yy = fx_mul(y, y, FRAC_BITS);
			xy2 = fx_mul(x, y, FRAC_BITS - 1);
			x = sat_sum(sat_sum(xx, -yy), cr);
			y = sat_sum(xy2, ci);
			n = n + 1;
			if (sat_sum(fx_mul(x, x, FRAC_BITS), fx_mul(y, y, FRAC_BITS)) > Q_FOUR)
				break;
		end
		v = (n << COLOR_SHIFT) / lim;
		res.column = col;
		res.row = rw;
		res.iterations = n[LIM_W-1:0];
		res.red = v[15:8];
		res.green = v[7:0];
		res.blue = v[23:16];
		return res;
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_hold_pct);
	end

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: iterations %0d rgb %02h %02h %02h",
						iterations, red, green, blue);
			end else begin
				want = pending_pixels.pop_front();
				if (iterations !== want.iterations || red !== want.red ||
						green !== want.green || blue !== want.blue) begin
					fail_count++;
					if (fail_count <= 10)
						$display("(%0d,%0d) want %0d %h %h %h got %0d %h %h %h",
							want.column, want.row, want.iterations, want.red, want.green,
							want.blue, iterations, red, green, blue);
				end
			end
		end
	end

	task automatic drive_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] rw);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		column <= col;
		row <= rw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_pixels.push_back(escape_pixel(col, rw));
	endtask

	// Hold off new pixels until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			mbet_pkg::CFG_OFFSET_X:   view_offset_x = data;
			mbet_pkg::CFG_OFFSET_Y:   view_offset_y = data;
			mbet_pkg::CFG_PIXEL_STEP: view_step = data;
			mbet_pkg::CFG_ITER_LIMIT: view_limit = data[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_view(input logic signed [31:0] ox, input logic signed [31:0] oy,
			input logic [31:0] step, input logic [LIM_W-1:0] lim);
		drain_results();
		write_reg(mbet_pkg::CFG_OFFSET_X, ox);
		write_reg(mbet_pkg::CFG_OFFSET_Y, oy);
		write_reg(mbet_pkg::CFG_PIXEL_STEP, step);
		write_reg(mbet_pkg::CFG_ITER_LIMIT, CFG_W'(lim));
		cfg_write <= 1'b0;
	endtask

	task automatic test_reset_view();
		drive_pixel(10'd0, 10'd0);
		drive_pixel(10'd1023, 10'd1023);
		drive_pixel(10'd1023, 10'd0);
		drive_pixel(10'd0, 10'd1023);
		drive_pixel(10'd150, 10'd190);
		drive_pixel(10'd100, 10'd190);
		drive_pixel(10'd682, 10'd341);
	endtask

	// |z|^2 equal to four does not count as escaped
	task automatic test_escape_boundary();
		set_view(32'sd4, 32'sd0, 32'h1000_0000, 16'd64);
		drive_pixel(10'd6, 10'd0);
		drive_pixel(10'd2, 10'd0);
		drive_pixel(10'd4, 10'd0);
		drive_pixel(10'd4, 10'd2);
	endtask

	// Coordinates far outside the Q4 range saturate
	task automatic test_far_offsets();
		set_view(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		drive_pixel(10'd0, 10'd0);
		drive_pixel(10'd1023, 10'd1023);
		set_view(32'sh7FFF_FFFF, 32'sh8000_0000, 32'h8000_0000, 16'd16);
		drive_pixel(10'd0, 10'd1023);
		drive_pixel(10'd1023, 10'd0);
	endtask

	// Zero step puts every pixel at the origin; zero limit acts as one
	task automatic test_zero_step();
		set_view(32'sd150, 32'sd190, 32'd0, 16'd0);
		drive_pixel(10'd0, 10'd0);
		drive_pixel(10'd1023, 10'd1023);
		set_view(32'sd0, 32'sd0, 32'd0, 16'd3);
		drive_pixel(10'd512, 10'd256);
	endtask

	task automatic test_deep_limit();
		set_view(32'sd0, 32'sd0, 32'd1, 16'hFFFF);
		drive_pixel(10'd1023, 10'd1023);
	endtask

	task automatic test_random_views(input int count);
		int sent;
		int group;
		int pick;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic [31:0] step;
		logic [LIM_W-1:0] lim;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(9);
			ox = $urandom_range(1023);
			oy = $urandom_range(1023);
			step = $urandom_range(32'h0020_0000, 32'h0002_0000);
			lim = LIM_W'($urandom_range(64, 1));
			if (pick == 0) begin
				ox = $urandom;
				oy = $urandom;
				step = $urandom;
			end else if (pick == 1) begin
				lim = LIM_W'($urandom_range(600, 200));
			end
			set_view(ox, oy, step, lim);
			group = $urandom_range(30, 15);
			if (group > count - sent)
				group = count - sent;
			repeat (group) begin
				drive_pixel(PIX_W'($urandom_range(1023)), PIX_W'($urandom_range(1023)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 32;
		recv_hold_pct = 65;
		test_reset_view();
		test_escape_boundary();
		test_far_offsets();
		test_zero_step();
		test_deep_limit();
		test_random_views(245);
		drain_results();
		send_gap_pct = 65;
		recv_hold_pct = 32;
		test_random_views(245);
		drain_results();
		send_gap_pct = 0;
		recv_hold_pct = 0;
		test_random_views(245);
		drain_results();
		repeat (100) @(posedge clk);
		if (pending_pixels.size() != 0)
			fail_count += pending_pixels.size();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
